[hdl/q4_block_dot_product_defines.svh]
// Assertion macros for the Q4 block dot product.
`ifndef Q4_BLOCK_DOT_PRODUCT_DEFINES_SVH
`define Q4_BLOCK_DOT_PRODUCT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define Q4BDP_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define Q4BDP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/q4bdp_pkg.sv]
// Shared types, constants and fp32 arithmetic functions for the Q4 block dot product.
package q4bdp_pkg;

	localparam logic [3:0]  NIB_BIAS   = 4'd8;
	localparam logic [15:0] H_SIGN     = 16'h8000;
	localparam logic [15:0] H_EXP      = 16'h7C00;
	localparam logic [15:0] H_MANT     = 16'h03FF;
	localparam logic [7:0]  EXP_REBIAS = 8'd112;
	localparam logic [31:0] F_INF_EXP  = 32'h7F800000;
	localparam logic [31:0] F_QNAN     = 32'h7FC00000;

	typedef struct packed {
		logic [31:0] scale;
		logic [31:0] w_low;
		logic [31:0] w_high;
		logic [31:0] act_low;
		logic [31:0] act_high;
		logic        last;
	} work_t;

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [4:0]  e;
		logic [9:0]  m;
		logic [3:0]  k;
		logic [9:0]  mn;
		logic [31:0] r;
		e = 5'((h & H_EXP) >> 10);
		m = 10'(h & H_MANT);
		k = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (m[i]) k = 4'(i);
		end
		mn = 10'(m << (4'd10 - k));
		if (e == 5'd0) begin
			if (m == 10'd0) r = {h[15], 31'b0};
			else r = {h[15], 8'(k) + EXP_REBIAS - 8'd9, mn, 13'b0};
		end else if (e == 5'h1F) begin
			r = {h[15], 31'b0} | F_INF_EXP | {9'b0, m, 13'b0};
		end else begin
			r = {h[15], 8'(e) + EXP_REBIAS, m, 13'b0};
		end
		return r;
	endfunction

	function automatic logic [31:0] nibble_to_single(input logic [3:0] n);
		logic [3:0]  mag;
		logic [1:0]  k;
		logic [26:0] t;
		mag = n[3] ? {1'b0, n[2:0]} : (NIB_BIAS - n);
		k = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (mag[i]) k = 2'(i);
		end
		t = {mag, 23'b0} >> k;
		if (mag == 4'd0) return 32'd0;
		return {~n[3], 8'd127 + 8'(k), t[22:0]};
	endfunction

	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		logic               sgn;
		logic [7:0]         ea, eb;
		logic [23:0]        ma, mb;
		logic [47:0]        p, pn, pr;
		logic [5:0]         lz;
		logic               found, lost, g, st, a_nan, b_nan, a_inf, b_inf, a_z, b_z;
		logic signed [10:0] e;
		logic signed [10:0] amt;
		logic [31:0]        pk;
		sgn = a[31] ^ b[31];
		ea = a[30:23];
		eb = b[30:23];
		a_nan = (&ea) && (|a[22:0]);
		b_nan = (&eb) && (|b[22:0]);
		a_inf = (&ea) && !(|a[22:0]);
		b_inf = (&eb) && !(|b[22:0]);
		a_z = !(|a[30:0]);
		b_z = !(|b[30:0]);
		ma = {|ea, a[22:0]};
		mb = {|eb, b[22:0]};
		p = ma * mb;
		lz = 6'd0;
		found = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!found && p[i]) begin
				lz = 6'(47 - i);
				found = 1'b1;
			end
		end
		pn = p << lz;
		e = $signed({3'b0, (ea == 8'd0) ? 8'd1 : ea}) + $signed({3'b0, (eb == 8'd0) ? 8'd1 : eb})
			- 11'sd126 - $signed({5'b0, lz});
		lost = 1'b0;
		pr = pn;
		if (e < 11'sd1) begin
			amt = 11'sd1 - e;
			if (amt > 11'sd48) begin
				pr = 48'd0;
				lost = |pn;
			end else begin
				pr = pn >> amt[5:0];
				lost = ((pr << amt[5:0]) != pn);
			end
		end
		g = pr[23];
		st = (|pr[22:0]) | lost;
		pk = {1'b0, (e < 11'sd1) ? 8'd0 : e[7:0], pr[46:24]};
		pk = pk + 32'(g & (st | pr[24]));
		if (a_nan || b_nan) return F_QNAN;
		if (a_inf || b_inf) begin
			if (a_z || b_z) return F_QNAN;
			return {sgn, 31'b0} | F_INF_EXP;
		end
		if (a_z || b_z) return {sgn, 31'b0};
		if (e > 11'sd254) return {sgn, 31'b0} | F_INF_EXP;
		return {sgn, pk[30:0]};
	endfunction

	function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] x, y, pk;
		logic [7:0]  ex, ey, d, lmax;
		logic [26:0] mx, my, my_s, t, s;
		logic [27:0] s28;
		logic [4:0]  lz;
		logic [8:0]  ef;
		logic        found, eq, a_nan, b_nan, a_inf, b_inf;
		a_nan = (&a[30:23]) && (|a[22:0]);
		b_nan = (&b[30:23]) && (|b[22:0]);
		a_inf = (&a[30:23]) && !(|a[22:0]);
		b_inf = (&b[30:23]) && !(|b[22:0]);
		if (a[30:0] >= b[30:0]) begin
			x = a;
			y = b;
		end else begin
			x = b;
			y = a;
		end
		ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		mx = {|x[30:23], x[22:0], 3'b0};
		my = {|y[30:23], y[22:0], 3'b0};
		d = ex - ey;
		if (d > 8'd26) begin
			my_s = {26'b0, |my};
		end else begin
			t = my >> d;
			my_s = t | 27'((t << d) != my);
		end
		eq = (x[31] == y[31]);
		s28 = eq ? ({1'b0, mx} + {1'b0, my_s}) : ({1'b0, mx} - {1'b0, my_s});
		lz = 5'd0;
		found = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!found && s28[i]) begin
				lz = 5'(26 - i);
				found = 1'b1;
			end
		end
		lmax = ex - 8'd1;
		if (s28[27]) begin
			s = s28[27:1] | {26'b0, s28[0]};
			ef = {1'b0, ex} + 9'd1;
		end else if ({3'b0, lz} <= lmax) begin
			s = s28[26:0] << lz;
			ef = {1'b0, ex} - {4'b0, lz};
		end else begin
			s = s28[26:0] << lmax;
			ef = 9'd0;
		end
		pk = {1'b0, ef[7:0], s[25:3]};
		pk = pk + 32'(s[2] & ((|s[1:0]) | s[3]));
		if (a_nan || b_nan) return F_QNAN;
		if (a_inf && b_inf) return (a[31] != b[31]) ? F_QNAN : a;
		if (a_inf) return a;
		if (b_inf) return b;
		if (s28 == 28'd0) return eq ? {x[31], 31'b0} : 32'd0;
		if (ef > 9'd254) return {x[31], 31'b0} | F_INF_EXP;
		return {x[31], pk[30:0]};
	endfunction

	function automatic logic [31:0] canon_nan(input logic [31:0] r);
		if (((r & F_INF_EXP) == F_INF_EXP) && (|r[22:0])) return F_QNAN;
		return r;
	endfunction

endpackage

[hdl/q4bdp_front.sv]
// Front end: widens the scale, converts both nibbles and queues the word for the back end.
module q4bdp_front import q4bdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] scale_bits,
	input  logic [7:0]  quant_byte,
	input  logic [31:0] act_low,
	input  logic [31:0] act_high,
	input  logic        last_pair,
	output logic        work_valid,
	input  logic        work_take,
	output work_t       work
);

	work_t       mem_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	logic        do_push, do_pop;
	work_t       entry;

	assign full       = (cnt_q == 2'd2);
	assign work_valid = (cnt_q != 2'd0);
	assign work       = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = work_valid && work_take;

	always_comb begin
		entry.scale    = half_to_single(scale_bits);
		entry.w_low    = nibble_to_single(quant_byte[3:0]);
		entry.w_high   = nibble_to_single(quant_byte[7:4]);
		entry.act_low  = act_low;
		entry.act_high = act_high;
		entry.last     = last_pair;
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

[hdl/q4bdp_back.sv]
// Back end: scale and activation products, accumulation, and the result queue.
module q4bdp_back import q4bdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        work_valid,
	output logic        work_take,
	input  work_t       work,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] sum_bits
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ADD0 = 2'd2;
	localparam logic [1:0] ST_ADD1 = 2'd3;

	logic [1:0]  state_q;
	logic [31:0] v0_q, v1_q, p0_q, p1_q, a0_q, a1_q, acc_q;
	logic        last_q;
	logic [31:0] out_q [2];
	logic        owr_q, ord_q;
	logic [1:0]  ocnt_q;
	logic [31:0] sum;
	logic        room, finish, out_push, out_pop;

	assign work_take = (state_q == ST_IDLE);
	assign sum       = fadd(acc_q, p1_q);
	assign room      = (ocnt_q != 2'd2);
	assign finish    = (state_q == ST_ADD1) && (!last_q || room);
	assign out_push  = finish && last_q;
	assign out_pop   = pop && !empty;
	assign empty     = (ocnt_q == 2'd0);
	assign sum_bits  = out_q[ord_q];

	always_ff @(posedge clk) begin
		if (work_take && work_valid) begin
			v0_q   <= fmul(work.w_low, work.scale);
			v1_q   <= fmul(work.w_high, work.scale);
			a0_q   <= work.act_low;
			a1_q   <= work.act_high;
			last_q <= work.last;
		end
		if (state_q == ST_MUL) begin
			p0_q <= fmul(v0_q, a0_q);
			p1_q <= fmul(v1_q, a1_q);
		end
		if (out_push) out_q[owr_q] <= canon_nan(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= 32'd0;
			owr_q   <= 1'b0;
			ord_q   <= 1'b0;
			ocnt_q  <= 2'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (work_valid) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ADD0;
				ST_ADD0: begin
					acc_q   <= fadd(acc_q, p0_q);
					state_q <= ST_ADD1;
				end
				ST_ADD1: begin
					if (finish) begin
						acc_q   <= last_q ? 32'd0 : sum;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_push) owr_q <= !owr_q;
			if (out_pop) ord_q <= !ord_q;
			ocnt_q <= ocnt_q + 2'(out_push) - 2'(out_pop);
		end
	end

endmodule

[hdl/q4_block_dot_product.sv]
// An accepted word leaves the input queue in IDLE (scale products registered), then passes MUL, ADD0 and ADD1.
// The back end takes a new word only in IDLE, after the last one has left ADD1; a closing word waits in ADD1 for room.
// Input queue and result queue hold two words each.
// Reset (arst_n low) empties both queues and sets the accumulator to +0.
// Top level of the Q4 block dot product.
module q4_block_dot_product import q4bdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] scale_bits,
	input  logic [7:0]  quant_byte,
	input  logic [31:0] act_low,
	input  logic [31:0] act_high,
	input  logic        last_pair,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] sum_bits
);

	logic  work_valid, work_take;
	work_t work;

	q4bdp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.scale_bits (scale_bits),
		.quant_byte (quant_byte),
		.act_low    (act_low),
		.act_high   (act_high),
		.last_pair  (last_pair),
		.work_valid (work_valid),
		.work_take  (work_take),
		.work       (work)
	);

	q4bdp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_valid (work_valid),
		.work_take  (work_take),
		.work       (work),
		.empty      (empty),
		.pop        (pop),
		.sum_bits   (sum_bits)
	);

endmodule

[hdl/q4bdp_checker.sv]
// Port-level checks for the Q4 block dot product, bound to the top level.
`include "q4_block_dot_product_defines.svh"

module q4bdp_checker import q4bdp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        pop,
	input logic        empty,
	input logic [31:0] sum_bits
);

	`Q4BDP_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(sum_bits), "result word changed while stalled")
	`Q4BDP_ASSERT_IMPLY(a_nan_canon, !empty && ((sum_bits & F_INF_EXP) == F_INF_EXP) && (sum_bits[22:0] != 23'd0), sum_bits == F_QNAN, "non-canonical NaN result")
	`Q4BDP_ASSERT_IMPLY(a_full_by_push, $rose(full), $past(push), "input queue filled without a push")

endmodule

bind q4_block_dot_product q4bdp_checker u_q4bdp_checker (.*);

[bench/tb.sv]
// Self-checking testbench for q4_block_dot_product: directed table, then random words checked by a predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = 600;
	localparam logic [31:0] QNAN = 32'h7FC00000;
	localparam logic [31:0] ONE_F = 32'h3F800000;
	localparam logic [15:0] ONE_H = 16'h3C00;

	typedef struct {
		logic [15:0] scale;
		logic [7:0]  q;
		logic [31:0] al;
		logic [31:0] ah;
		logic        last;
		logic        known;
		logic [31:0] sum;
	} row_t;

	logic        clk, arst_n, push, full, empty, pop, last_pair;
	logic [15:0] scale_bits;
	logic [7:0]  quant_byte;
	logic [31:0] act_low, act_high, sum_bits;

	logic [31:0] acc_sum;
	logic [31:0] sums_due[$];
	int          errs;
	bit          hold;
	bit          sending;

	q4_block_dot_product uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// round y * 2^-309 to fp32, y nonzero
	function automatic logic [31:0] round_f32(input logic s, input logic [W-1:0] y);
		int          p, r;
		logic [W-1:0] keep, lo;
		longint      bits;
		logic        g, st;
		p = 0;
		for (int i = W - 1; i >= 0; i--) begin
			if (y[i]) begin
				p = i;
				break;
			end
		end
		r = (p - 23 > 160) ? p - 23 : 160;
		keep = y >> r;
		g = y[r-1];
		lo = y << (W - r + 1);
		st = |lo;
		bits = (longint'(r - 160) << 23) + longint'(keep[24:0]) + longint'(g & (st | keep[0]));
		if (bits >= 64'h7F800000) return {s, 31'h7F800000};
		return {s, bits[30:0]};
	endfunction

	function automatic bit is_nan(input logic [31:0] a);
		return (&a[30:23]) && (|a[22:0]);
	endfunction

	function automatic bit is_inf(input logic [31:0] a);
		return (&a[30:23]) && !(|a[22:0]);
	endfunction

	function automatic logic [W-1:0] magnitude(input logic [31:0] a, input int shift);
		logic [W-1:0] y;
		y = W'({|a[30:23], a[22:0]});
		return y << (((a[30:23] == 8'd0) ? 1 : int'(a[30:23])) + shift);
	endfunction

	function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
		logic s;
		logic [W-1:0] y;
		s = a[31] ^ b[31];
		if (is_nan(a) || is_nan(b)) return QNAN;
		if (is_inf(a) || is_inf(b)) begin
			if (a[30:0] == 0 || b[30:0] == 0) return QNAN;
			return {s, 31'h7F800000};
		end
		if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'b0};
		y = magnitude(a, 0) * magnitude(b, 0);
		return round_f32(s, y << 9);
	endfunction

	function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
		logic [W-1:0] ya, yb;
		if (is_nan(a) || is_nan(b)) return QNAN;
		if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? QNAN : a;
		if (is_inf(a)) return a;
		if (is_inf(b)) return b;
		ya = magnitude(a, 159);
		yb = magnitude(b, 159);
		if (a[31] == b[31]) begin
			if (ya + yb == 0) return {a[31], 31'b0};
			return round_f32(a[31], ya + yb);
		end
		if (ya > yb) return round_f32(a[31], ya - yb);
		if (yb > ya) return round_f32(b[31], yb - ya);
		return 32'd0;
	endfunction

	function automatic logic [31:0] widen_half(input logic [15:0] h);
		logic [W-1:0] y;
		if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'b0};
		if (h[14:0] == 0) return {h[15], 31'b0};
		if (h[14:10] == 0) begin
			y = W'(h[9:0]);
			return round_f32(h[15], y << 285);
		end
		y = W'({1'b1, h[9:0]});
		return round_f32(h[15], y << (int'(h[14:10]) + 284));
	endfunction

	function automatic logic [31:0] nibble_f32(input logic [3:0] n);
		int w;
		logic [W-1:0] y;
		w = int'(n) - 8;
		if (w == 0) return 32'd0;
		y = W'((w < 0) ? -w : w);
		return round_f32(w < 0, y << 309);
	endfunction

	// returns 1 when the word closes a dot product; sum then holds the result
	function automatic bit dot_accumulate(input row_t r, output logic [31:0] sum);
		logic [31:0] d;
		d = widen_half(r.scale);
		acc_sum = f32_add(acc_sum, f32_mul(f32_mul(nibble_f32(r.q[3:0]), d), r.al));
		acc_sum = f32_add(acc_sum, f32_mul(f32_mul(nibble_f32(r.q[7:4]), d), r.ah));
		sum = acc_sum;
		if (!r.last) return 1'b0;
		if (is_nan(sum)) sum = QNAN;
		acc_sum = 32'd0;
		return 1'b1;
	endfunction

	function automatic logic [31:0] rand_act();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) return $urandom;
		if (k == 1) return {1'($urandom_range(0, 1)), 8'($urandom_range(0, 3)), 23'($urandom)};
		return {1'($urandom_range(0, 1)), 8'($urandom_range(110, 140)), 23'($urandom)};
	endfunction

	function automatic row_t rand_row(input bit last);
		row_t r;
		int k;
		k = $urandom_range(0, 19);
		if (k == 0) r.scale = 16'($urandom);
		else if (k == 1) r.scale = {1'($urandom_range(0, 1)), 5'd0, 10'($urandom)};
		else if (k == 2) r.scale = {1'($urandom_range(0, 1)), 5'h1F, 10'($urandom_range(0, 3))};
		else r.scale = {1'($urandom_range(0, 1)), 5'($urandom_range(5, 20)), 10'($urandom)};
		r.q = 8'($urandom);
		r.al = rand_act();
		r.ah = rand_act();
		r.last = last;
		r.known = 1'b0;
		r.sum = '0;
		return r;
	endfunction

	task automatic send_word(input row_t r);
		logic [31:0] s;
		push <= 1'b1;
		scale_bits <= r.scale;
		quant_byte <= r.q;
		act_low <= r.al;
		act_high <= r.ah;
		last_pair <= r.last;
		do @(posedge clk); while (full);
		if (dot_accumulate(r, s)) sums_due.push_back(r.known ? r.sum : s);
		if ($urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
				@(posedge clk);
		end
	endtask

	// result side
	initial begin
		int stall;
		stall = 0;
		pop = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (sums_due.size() == 0) begin
					$display("%0t: unexpected word sum_bits=%h", $time, sum_bits);
					errs++;
				end else begin
					if (sum_bits !== sums_due[0]) begin
						$display("%0t: sum_bits expected %h actual %h", $time, sums_due[0],
							sum_bits);
						errs++;
					end
					void'(sums_due.pop_front());
				end
			end
			if (stall > 0) stall--;
			else if ($urandom_range(0, 3) == 0)
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			pop <= !hold && stall == 0;
		end
	end

	// long receiver hold-off so the block fills and stalls its input
	initial begin
		hold = 1'b0;
		wait (sending);
		repeat (300) @(posedge clk);
		hold = 1'b1;
		repeat (400) @(posedge clk);
		hold = 1'b0;
	end

	initial begin
		row_t tbl[$];
		row_t r;
		errs = 0;
		acc_sum = 32'd0;
		sending = 1'b0;
		push = 1'b0;
		scale_bits = '0;
		quant_byte = '0;
		act_low = '0;
		act_high = '0;
		last_pair = 1'b0;
		arst_n = 1'b0;
		tbl = '{
			'{ONE_H, 8'h88, ONE_F, ONE_F, 1'b1, 1'b1, 32'h00000000},
			'{ONE_H, 8'h00, ONE_F, ONE_F, 1'b1, 1'b1, 32'hC1800000},
			'{ONE_H, 8'hFF, ONE_F, ONE_F, 1'b1, 1'b1, 32'h41600000},
			'{16'h0000, 8'h5A, ONE_F, ONE_F, 1'b1, 1'b1, 32'h00000000},
			'{16'h7C00, 8'h88, ONE_F, ONE_F, 1'b1, 1'b1, QNAN},
			'{ONE_H, 8'h12, 32'h7FC00001, ONE_F, 1'b1, 1'b1, QNAN},
			'{ONE_H, 8'h9F, 32'hFFFFFFFF, 32'h7F800000, 1'b1, 1'b0, 32'h0},
			'{16'h7C00, 8'hF0, ONE_F, ONE_F, 1'b1, 1'b1, QNAN},
			'{16'hFC01, 8'h13, ONE_F, ONE_F, 1'b1, 1'b1, QNAN},
			'{16'h0001, 8'hF7, 32'h7F7FFFFF, 32'h00000001, 1'b1, 1'b0, 32'h0},
			'{16'h03FF, 8'h0F, 32'h00800000, 32'h80800000, 1'b1, 1'b0, 32'h0},
			'{16'h7BFF, 8'h00, 32'h7F7FFFFF, 32'h7F7FFFFF, 1'b1, 1'b1, 32'hFF800000},
			'{16'hFBFF, 8'hF1, 32'h3F800001, 32'hBF7FFFFF, 1'b0, 1'b0, 32'h0},
			'{16'hFBFF, 8'h1F, 32'h7F800000, 32'hFF800000, 1'b1, 1'b0, 32'h0},
			'{16'h3555, 8'hA7, 32'h3DCCCCCD, 32'h40490FDB, 1'b0, 1'b0, 32'h0},
			'{16'h3555, 8'h6C, 32'hC0490FDB, 32'h3DCCCCCD, 1'b0, 1'b0, 32'h0},
			'{16'h3555, 8'h3E, 32'h80000001, 32'h00000001, 1'b1, 1'b0, 32'h0},
			'{16'h8000, 8'h00, ONE_F, ONE_F, 1'b1, 1'b0, 32'h0}
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sending = 1'b1;
		foreach (tbl[i]) send_word(tbl[i]);
		repeat (1850) begin
			r = rand_row($urandom_range(0, 7) == 0);
			send_word(r);
		end
		send_word(rand_row(1'b1));
		push <= 1'b0;
		wait (sums_due.size() == 0);
		repeat (20) @(posedge clk);
		if (errs == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
